// ===== rtl/smwl_pkg.sv =====
// Shared types, codes and constants for the stepper move-with-limits unit.
package smwl_pkg;

    // Fixed field widths
    localparam int CMD_W        = 2;
    localparam int STEP_W       = 32;
    localparam int REASON_W     = 2;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    // Parameter defaults
    localparam int COUNT_BITS_DEF = 32;
    localparam int DELAY_BITS_DEF = 16;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RST = 16'd10;
    localparam logic                  MICRO_FINE_RST  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_MICRO_FINE  = 1'b1
    } cfg_reg_t;

    // Command codes; the spare code behaves as a tick
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CAL   = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    // Stop reasons
    typedef enum logic [REASON_W-1:0] {
        RSN_DONE  = 2'd0,
        RSN_SOFT  = 2'd1,
        RSN_FRONT = 2'd2,
        RSN_BACK  = 2'd3
    } reason_t;

    // Pulse phase of the current step
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    localparam logic [MODE_W-1:0] MODE_FINE = 3'd7;
    localparam logic [MODE_W-1:0] MODE_FULL = 3'd0;

    // One result item
    typedef struct packed {
        logic               step_line;
        logic               dir_line;
        logic [MODE_W-1:0]  mode_lines;
        logic               busy_res;
        logic               finished;
        reason_t            stop_reason;
        logic [STEP_W-1:0]  steps_moved;
    } res_t;

endpackage

// ===== rtl/stepper_move_with_limits_unit.sv =====
// Top level of the stepper step/direction pulse generator with limit switches.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a tick of
//   time (cmd TICK) or a command (MOVE with a signed step count, CAL with a
//   direction), plus the limit switch levels and the soft stop request.
//   Every input item produces exactly one result item on the output channel
//   (out_valid/out_ready): step and direction line levels, mode lines, busy,
//   a one-item finished pulse, the stop reason and the signed steps moved.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   half period in ticks and the microstep mode; cfg_ready is always high.
// Timing:
//   Each result is registered into the result register, or into the skid
//   register while the receiver stalls. One item is accepted every cycle
//   while the skid register is empty; the whole state update is a single
//   registered pass. The two-entry output stage keeps in_ready high for one
//   extra item on a stall; in_ready drops only when both entries are full.
// Reset:
//   rst_n clears the motion state and the output stage, and sets the half
//   period to 10 ticks and the mode lines to fine.
module stepper_move_with_limits_unit
    import smwl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [STEP_W-1:0] step_count,
    input  logic                     direction,
    input  logic                     front_limit,
    input  logic                     back_limit,
    input  logic                     stop_request,
    // result items
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     step_line,
    output logic                     dir_line,
    output logic [MODE_W-1:0]        mode_lines,
    output logic                     busy_res,
    output logic                     finished,
    output logic [REASON_W-1:0]      stop_reason,
    output logic signed [STEP_W-1:0] steps_moved
);

    localparam int CNT_W = COUNT_BITS - 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration registers
    logic [CFG_DATA_W-1:0] half_period_reg;
    logic                  micro_fine_reg;

    // Motion state
    logic                  active_reg,   active_next;
    logic                  cal_reg,      cal_next;
    logic                  back_reg,     back_next;
    logic [CNT_W-1:0]      left_reg,     left_next;
    logic [CNT_W-1:0]      done_reg,     done_next;
    phase_t                phase_reg,    phase_next;
    logic [DELAY_BITS-1:0] tick_reg,     tick_next;
    logic                  stop_reg,     stop_next;
    reason_t               reason_reg,   reason_next;

    // Output stage
    res_t                  out_reg;
    res_t                  skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    logic                  in_xfer;
    logic                  fin;
    logic                  do_check;
    logic                  end_cmd;
    reason_t               chk_reason;
    logic [31:0]           hp_wide;
    logic [DELAY_BITS-1:0] hp;
    logic [STEP_W-1:0]     mag;
    logic [STEP_W-1:0]     done_ext;
    res_t                  res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;

    // Half period seen at the tick counter width
    assign hp_wide = 32'(half_period_reg);
    assign hp      = hp_wide[DELAY_BITS-1:0];

    // Magnitude of the move count; it is saturated to the counter range when a move starts
    always_comb
    begin
        if (step_count[STEP_W-1])
        begin
            mag = STEP_W'(0) - step_count;
        end
        else
        begin
            mag = step_count;
        end
    end

    // Compute next motion state for the item on the input ports
    always_comb
    begin
        active_next = active_reg;
        cal_next    = cal_reg;
        back_next   = back_reg;
        left_next   = left_reg;
        done_next   = done_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        stop_next   = stop_reg;
        reason_next = reason_reg;
        fin         = 1'b0;
        do_check    = 1'b0;
        end_cmd     = 1'b0;
        chk_reason  = RSN_DONE;

        if (active_reg && stop_request)
        begin
            stop_next = 1'b1;
        end

        if (!active_reg && (cmd inside {CMD_MOVE, CMD_CAL}))
        begin
            // start a command
            active_next = 1'b1;
            done_next   = '0;
            phase_next  = PH_IDLE;
            tick_next   = '0;
            stop_next   = 1'b0;
            if (cmd == CMD_MOVE)
            begin
                cal_next  = 1'b0;
                back_next = step_count[STEP_W-1];
                if (mag > STEP_W'(COUNT_MAX))
                begin
                    left_next = COUNT_MAX;
                end
                else
                begin
                    left_next = mag[CNT_W-1:0];
                end
            end
            else
            begin
                cal_next  = 1'b1;
                back_next = direction;
                left_next = '0;
            end
        end
        else if ((cmd inside {CMD_TICK, CMD_SPARE}) && active_reg)
        begin
            // advance the pulse timing
            case (phase_reg)
                PH_HIGH:
                begin
                    if (tick_reg >= hp)
                    begin
                        phase_next = PH_LOW;
                        tick_next  = DELAY_BITS'(1);
                    end
                    else
                    begin
                        tick_next = tick_reg + DELAY_BITS'(1);
                    end
                end
                PH_LOW:
                begin
                    if (tick_reg >= hp)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        if (done_reg < COUNT_MAX)
                        begin
                            done_next = done_reg + CNT_W'(1);
                        end
                        if (!cal_reg && left_reg != '0)
                        begin
                            left_next = left_reg - CNT_W'(1);
                        end
                        do_check = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_reg + DELAY_BITS'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    do_check   = 1'b1;
                end
            endcase

            // run the checks before the next step
            if (do_check)
            begin
                if (!cal_reg && left_next == '0)
                begin
                    end_cmd    = 1'b1;
                    chk_reason = RSN_DONE;
                end
                else if (stop_next)
                begin
                    end_cmd    = 1'b1;
                    chk_reason = RSN_SOFT;
                end
                else if (!back_reg && front_limit)
                begin
                    end_cmd    = 1'b1;
                    chk_reason = RSN_FRONT;
                end
                else if (back_reg && back_limit)
                begin
                    end_cmd    = 1'b1;
                    chk_reason = RSN_BACK;
                end
                else
                begin
                    phase_next = PH_HIGH;
                    tick_next  = DELAY_BITS'(1);
                end

                if (end_cmd)
                begin
                    active_next = 1'b0;
                    fin         = 1'b1;
                    reason_next = chk_reason;
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                end
            end
        end
    end

    // Build the result item from the updated state
    assign done_ext = STEP_W'(done_next);

    always_comb
    begin
        res.step_line   = (phase_next == PH_HIGH);
        res.dir_line    = back_next;
        res.mode_lines  = micro_fine_reg ? MODE_FINE : MODE_FULL;
        res.busy_res    = active_next;
        res.finished    = fin;
        res.stop_reason = reason_next;
        res.steps_moved = back_next ? (STEP_W'(0) - done_ext) : done_ext;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            micro_fine_reg  <= MICRO_FINE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data;
                REG_MICRO_FINE:  micro_fine_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Motion state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cal_reg    <= 1'b0;
            back_reg   <= 1'b0;
            left_reg   <= '0;
            done_reg   <= '0;
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            stop_reg   <= 1'b0;
            reason_reg <= RSN_DONE;
        end
        else if (in_xfer)
        begin
            active_reg <= active_next;
            cal_reg    <= cal_next;
            back_reg   <= back_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            stop_reg   <= stop_next;
            reason_reg <= reason_next;
        end
    end

    // Output stage valid bits: hold on stall, spill into the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (out_valid_reg && out_ready && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign step_line   = out_reg.step_line;
    assign dir_line    = out_reg.dir_line;
    assign mode_lines  = out_reg.mode_lines;
    assign busy_res    = out_reg.busy_res;
    assign finished    = out_reg.finished;
    assign stop_reason = out_reg.stop_reason;
    assign steps_moved = out_reg.steps_moved;

    // Skid entry is only ever filled behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // A finishing result never reports busy
    a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.finished && out_reg.busy_res))
        else $error("finished and busy on the same result");

    // Pulse timing only runs while a command is active
    a_phase_active: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> active_reg)
        else $error("pulse phase running while idle");

    // State changes only on an input transfer
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_xfer |=> $stable(active_reg) && $stable(done_reg))
        else $error("motion state changed without an input transfer");

endmodule
